[hw/rtl/mbdi_pkg.sv]
// Shared types, codes and helpers of the memory bus decoder with interrupts.
`default_nettype none
package mbdi_pkg;

  localparam int WORK_RAM_BYTES_DEF = 8192;
  localparam int HRAM_DEPTH         = 127;
  localparam int HRAM_AW            = $clog2(HRAM_DEPTH);

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_IDLE  = 2'd3;

  localparam logic [3:0] TGT_LOCAL   = 4'd0;
  localparam logic [3:0] TGT_BOOT    = 4'd1;
  localparam logic [3:0] TGT_CART    = 4'd2;
  localparam logic [3:0] TGT_VRAM    = 4'd3;
  localparam logic [3:0] TGT_XRAM    = 4'd4;
  localparam logic [3:0] TGT_OAM     = 4'd5;
  localparam logic [3:0] TGT_TIMER   = 4'd6;
  localparam logic [3:0] TGT_SOUND   = 4'd7;
  localparam logic [3:0] TGT_DISPLAY = 4'd8;
  localparam logic [3:0] TGT_IGNORED = 4'd9;
  localparam logic [3:0] TGT_ERROR   = 4'd10;

  localparam logic [7:0] JOYP_RST = 8'hCF;
  localparam logic [7:0] SB_RST   = 8'h00;
  localparam logic [7:0] SC_RST   = 8'h7E;
  localparam logic [7:0] IF_RST   = 8'hE1;
  localparam logic [7:0] IE_RST   = 8'hE0;
  localparam logic [7:0] BOOT_RST = 8'hFF;

  localparam logic [15:0] ADDR_JOYP = 16'hFF00;
  localparam logic [15:0] ADDR_SB   = 16'hFF01;
  localparam logic [15:0] ADDR_SC   = 16'hFF02;
  localparam logic [15:0] ADDR_IF   = 16'hFF0F;
  localparam logic [15:0] ADDR_BOOT = 16'hFF50;
  localparam logic [15:0] ADDR_IE   = 16'hFFFF;

  typedef struct packed {
    logic [7:0] joyp;
    logic [7:0] sb;
    logic [7:0] sc;
    logic [7:0] iflag;
    logic [7:0] ie;
    logic [7:0] boot;
  } regs_t;

  typedef struct packed {
    logic [3:0]  target;
    logic [14:0] offset;
    logic [7:0]  read_data;
    logic        serial_valid;
    logic [7:0]  serial_byte;
    logic        irq_request;
    logic [2:0]  irq_index;
    logic        rd_wram;
    logic        rd_hram;
  } res_t;

  typedef struct packed {
    logic wram_we;
    logic wram_re;
    logic hram_we;
    logic hram_re;
  } mem_req_t;

  function automatic logic [2:0] lowest_set(input logic [4:0] v);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 4; i >= 0; i--) begin
      if (v[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/mbdi_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module mbdi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/mbdi_decode.sv]
// Address decode, local register update and interrupt poll for one word.
`default_nettype none
module mbdi_decode import mbdi_pkg::*; (
  input  wire logic [1:0]  operation,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  write_data,
  input  wire logic [4:0]  irq_raise,
  input  wire logic        cpu_busy,
  input  wire logic        cpu_accepts,
  input  wire regs_t       regs,
  output regs_t            regs_nxt,
  output res_t             res,
  output mem_req_t         mreq
);

  logic [15:0] a;
  logic [7:0]  sc_new;
  logic [7:0]  sb_new;
  logic [7:0]  flags;
  logic [4:0]  pend;
  logic [2:0]  idx;

  assign a = address;

  always_comb begin
    regs_nxt = regs;
    res      = '0;
    mreq     = '0;
    res.target = TGT_IGNORED;
    sb_new = regs.sb;
    sc_new = regs.sc;
    flags  = regs.iflag;
    pend   = '0;
    idx    = '0;
    unique case (operation)
      OP_READ: begin
        res.read_data = 8'hFF;
        priority if (a <= 16'h7FFF) begin
          res.target = (!regs.boot[0] && a < 16'h0100) ? TGT_BOOT : TGT_CART;
          res.offset = a[14:0];
          res.read_data = '0;
        end else if (a <= 16'h9FFF) begin
          res.target = TGT_VRAM;
          res.offset = {2'b00, a[12:0]};
          res.read_data = '0;
        end else if (a <= 16'hBFFF) begin
          res.target = TGT_XRAM;
          res.offset = {2'b00, a[12:0]};
          res.read_data = '0;
        end else if (a <= 16'hDFFF) begin
          res.target = TGT_LOCAL;
          res.offset = {2'b00, a[12:0]};
          res.rd_wram = 1'b1;
          mreq.wram_re = 1'b1;
        end else if (a >= 16'hFE00 && a <= 16'hFE9F) begin
          res.target = TGT_OAM;
          res.offset = {7'd0, a[7:0]};
          res.read_data = '0;
        end else if (a == ADDR_JOYP) begin
          res.target = TGT_LOCAL;
          res.read_data = regs.joyp;
        end else if (a == ADDR_SB) begin
          res.target = TGT_LOCAL;
          res.read_data = regs.sb;
        end else if (a == ADDR_SC) begin
          res.target = TGT_LOCAL;
          res.offset = 15'd1;
          res.read_data = regs.sc;
        end else if (a >= 16'hFF04 && a <= 16'hFF07) begin
          res.target = TGT_TIMER;
          res.offset = {7'd0, a[7:0] - 8'h04};
          res.read_data = '0;
        end else if (a >= 16'hFF10 && a <= 16'hFF26) begin
          res.target = TGT_SOUND;
          res.offset = {7'd0, a[7:0] - 8'h10};
          res.read_data = '0;
        end else if (a >= 16'hFF40 && a <= 16'hFF4B) begin
          res.target = TGT_DISPLAY;
          res.offset = {7'd0, a[7:0] - 8'h40};
          res.read_data = '0;
        end else if (a == ADDR_IF) begin
          res.target = TGT_LOCAL;
          res.read_data = regs.iflag;
        end else if (a == ADDR_BOOT) begin
          res.target = TGT_LOCAL;
          res.read_data = regs.boot;
        end else if (a >= 16'hFF80 && a <= 16'hFFFE) begin
          res.target = TGT_LOCAL;
          res.offset = {8'd0, a[6:0]};
          res.rd_hram = 1'b1;
          mreq.hram_re = 1'b1;
        end else if (a == ADDR_IE) begin
          res.target = TGT_LOCAL;
          res.read_data = regs.ie;
        end else begin
          res.target = TGT_IGNORED;
        end
      end
      OP_WRITE: begin
        priority if (a <= 16'h7FFF) begin
          res.target = TGT_CART;
          res.offset = a[14:0];
        end else if (a <= 16'h9FFF) begin
          res.target = TGT_VRAM;
          res.offset = {2'b00, a[12:0]};
        end else if (a <= 16'hBFFF) begin
          res.target = TGT_XRAM;
          res.offset = {2'b00, a[12:0]};
        end else if (a <= 16'hDFFF) begin
          res.target = TGT_LOCAL;
          res.offset = {2'b00, a[12:0]};
          mreq.wram_we = 1'b1;
        end else if (a >= 16'hFE00 && a <= 16'hFE9F) begin
          res.target = TGT_OAM;
          res.offset = {7'd0, a[7:0]};
        end else if (a < 16'hFE00) begin
          res.target = TGT_ERROR;
          res.offset = {2'b00, a[12:0]};
        end else if (a == ADDR_JOYP) begin
          res.target = TGT_LOCAL;
          regs_nxt.joyp = (regs.joyp & 8'hCF) | (write_data & 8'h30);
        end else if (a == ADDR_SB || a == ADDR_SC) begin
          res.target = TGT_LOCAL;
          res.offset = {14'd0, a[1]};
          if (a == ADDR_SB) begin
            sb_new = write_data;
          end else begin
            sc_new = (regs.sc & 8'h7E) | (write_data & 8'h81);
          end
          if (sc_new == 8'hFF) begin
            res.serial_valid = 1'b1;
            res.serial_byte  = sb_new;
            sc_new = sc_new & 8'h7F;
          end
          regs_nxt.sb = sb_new;
          regs_nxt.sc = sc_new;
        end else if (a >= 16'hFF04 && a <= 16'hFF07) begin
          res.target = TGT_TIMER;
          res.offset = {7'd0, a[7:0] - 8'h04};
        end else if (a >= 16'hFF10 && a <= 16'hFF26) begin
          res.target = TGT_SOUND;
          res.offset = {7'd0, a[7:0] - 8'h10};
        end else if (a >= 16'hFF40 && a <= 16'hFF4B) begin
          res.target = TGT_DISPLAY;
          res.offset = {7'd0, a[7:0] - 8'h40};
        end else if (a == ADDR_IF) begin
          res.target = TGT_LOCAL;
          regs_nxt.iflag = (regs.iflag & 8'hE0) | (write_data & 8'h1F);
        end else if (a == ADDR_BOOT) begin
          if (!regs.boot[0]) begin
            res.target = TGT_LOCAL;
            regs_nxt.boot = regs.boot | {7'd0, write_data[0]};
          end
        end else if (a >= 16'hFF80 && a <= 16'hFFFE) begin
          res.target = TGT_LOCAL;
          res.offset = {8'd0, a[6:0]};
          mreq.hram_we = 1'b1;
        end else if (a == ADDR_IE) begin
          res.target = TGT_LOCAL;
          regs_nxt.ie = write_data;
        end else begin
          res.target = TGT_IGNORED;
        end
      end
      OP_TICK: begin
        flags = regs.iflag | {3'd0, irq_raise};
        if (!cpu_busy) begin
          pend = flags[4:0] & regs.ie[4:0];
          idx  = lowest_set(pend);
          if (pend != 5'd0) begin
            res.irq_request = 1'b1;
            res.irq_index   = idx;
            if (cpu_accepts) begin
              flags[idx] = 1'b0;
            end
          end
        end
        regs_nxt.iflag = flags;
      end
      OP_IDLE: begin
        res.target = TGT_IGNORED;
      end
      default: begin
        res.target = TGT_IGNORED;
      end
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/memory_bus_decoder_with_interrupts_top.sv]
// Top level of the memory bus decoder with interrupt controller.
// An accepted word is registered first in stage s1 and then in the output register.
// Throughput: one word per cycle while out_ready holds and no work RAM sweep is running.
// Reset: local registers take their reset values at once; work RAM is then swept to zero,
// one entry a cycle through its write port, while no input word is accepted.
`default_nettype none
module memory_bus_decoder_with_interrupts_top import mbdi_pkg::*; #(
  parameter int WORK_RAM_BYTES = WORK_RAM_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_write_data,
  input  wire logic [4:0]  in_irq_raise,
  input  wire logic        in_cpu_busy,
  input  wire logic        in_cpu_accepts,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_target,
  output logic [14:0]      out_offset,
  output logic [7:0]       out_read_data,
  output logic             out_serial_valid,
  output logic [7:0]       out_serial_byte,
  output logic             out_irq_request,
  output logic [2:0]       out_irq_index
);

  localparam int WRAM_AW = $clog2(WORK_RAM_BYTES);

  regs_t    regs_r;
  regs_t    regs_nxt;
  res_t     dec_res;
  mem_req_t mreq;

  logic               clr_busy_r;
  logic [WRAM_AW-1:0] clr_addr_r;

  logic s1_valid_r;
  res_t s1_res_r;
  logic s1_adv;
  logic accept;

  logic               wram_we;
  logic [WRAM_AW-1:0] wram_waddr;
  logic [7:0]         wram_wdata;
  logic [7:0]         wram_rdata;
  logic [7:0]         hram_rdata;

  logic        out_valid_r;
  logic [3:0]  out_target_r;
  logic [14:0] out_offset_r;
  logic [7:0]  out_read_data_r;
  logic        out_serial_valid_r;
  logic [7:0]  out_serial_byte_r;
  logic        out_irq_request_r;
  logic [2:0]  out_irq_index_r;

  mbdi_decode u_decode (
    .operation   (in_operation),
    .address     (in_address),
    .write_data  (in_write_data),
    .irq_raise   (in_irq_raise),
    .cpu_busy    (in_cpu_busy),
    .cpu_accepts (in_cpu_accepts),
    .regs        (regs_r),
    .regs_nxt    (regs_nxt),
    .res         (dec_res),
    .mreq        (mreq)
  );

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clr_busy_r && (!s1_valid_r || s1_adv);
  assign accept   = in_valid && in_ready;

  assign wram_we    = clr_busy_r || (accept && mreq.wram_we);
  assign wram_waddr = clr_busy_r ? clr_addr_r : in_address[WRAM_AW-1:0];
  assign wram_wdata = clr_busy_r ? 8'h00 : in_write_data;

  mbdi_ram #(
    .WIDTH (8),
    .DEPTH (WORK_RAM_BYTES)
  ) u_wram (
    .clk   (clk),
    .we    (wram_we),
    .waddr (wram_waddr),
    .wdata (wram_wdata),
    .re    (accept && mreq.wram_re),
    .raddr (in_address[WRAM_AW-1:0]),
    .rdata (wram_rdata)
  );

  mbdi_ram #(
    .WIDTH (8),
    .DEPTH (HRAM_DEPTH)
  ) u_hram (
    .clk   (clk),
    .we    (accept && mreq.hram_we),
    .waddr (in_address[HRAM_AW-1:0]),
    .wdata (in_write_data),
    .re    (accept && mreq.hram_re),
    .raddr (in_address[HRAM_AW-1:0]),
    .rdata (hram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == WRAM_AW'(WORK_RAM_BYTES - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '{joyp: JOYP_RST, sb: SB_RST, sc: SC_RST,
                  iflag: IF_RST, ie: IE_RST, boot: BOOT_RST};
    end else if (accept) begin
      regs_r <= regs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r <= dec_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_target_r       <= s1_res_r.target;
      out_offset_r       <= s1_res_r.offset;
      out_serial_valid_r <= s1_res_r.serial_valid;
      out_serial_byte_r  <= s1_res_r.serial_byte;
      out_irq_request_r  <= s1_res_r.irq_request;
      out_irq_index_r    <= s1_res_r.irq_index;
      if (s1_res_r.rd_wram) begin
        out_read_data_r <= wram_rdata;
      end else if (s1_res_r.rd_hram) begin
        out_read_data_r <= hram_rdata;
      end else begin
        out_read_data_r <= s1_res_r.read_data;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_target       = out_target_r;
  assign out_offset       = out_offset_r;
  assign out_read_data    = out_read_data_r;
  assign out_serial_valid = out_serial_valid_r;
  assign out_serial_byte  = out_serial_byte_r;
  assign out_irq_request  = out_irq_request_r;
  assign out_irq_index    = out_irq_index_r;

`ifndef ASSERT_OFF
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ready)
    else $error("input accepted during work RAM sweep");

  a_serial_is_local: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_serial_valid) |-> (out_target == TGT_LOCAL))
    else $error("serial byte on a non-local word");

  a_irq_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_irq_request) |-> (out_irq_index <= 3'd4 && out_target == TGT_IGNORED))
    else $error("bad interrupt request word");

  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced word lost from output register");
`endif

endmodule
`default_nettype wire

[bench/tb_memory_bus_decoder_with_interrupts_top.sv]
// Self-checking testbench for the memory bus decoder with interrupt controller.
`default_nettype none
module tb_memory_bus_decoder_with_interrupts_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mbdi_pkg::*;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [4:0]  raise;
    logic        busy;
    logic        accepts;
  } bus_word_t;

  typedef struct packed {
    logic [3:0]  target;
    logic [14:0] offset;
    logic [7:0]  read_data;
    logic        serial_valid;
    logic [7:0]  serial_byte;
    logic        irq_request;
    logic [2:0]  irq_index;
  } bus_result_t;

  typedef struct {
    bus_word_t   w;
    bit          typed;
    bus_result_t r;
  } dir_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = OP_IDLE;
  logic [15:0] in_address = '0;
  logic [7:0]  in_write_data = '0;
  logic [4:0]  in_irq_raise = '0;
  logic        in_cpu_busy = 1'b0;
  logic        in_cpu_accepts = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_target;
  logic [14:0] out_offset;
  logic [7:0]  out_read_data;
  logic        out_serial_valid;
  logic [7:0]  out_serial_byte;
  logic        out_irq_request;
  logic [2:0]  out_irq_index;

  logic [7:0] wram_model [WORK_RAM_BYTES_DEF];
  logic [7:0] hram_model [HRAM_DEPTH];
  bit         hram_seen  [HRAM_DEPTH];
  int         hram_used[$];
  logic [7:0] joyp_q, sb_q, sc_q, if_q, ie_q, boot_q;

  bus_result_t awaited_results[$];
  dir_row_t    dir_rows[$];
  int unsigned bad_fields = 0;
  int unsigned words_sent = 0;
  int unsigned n_reads = 0, n_writes = 0, n_ticks = 0, n_serial = 0, n_irq = 0;
  int unsigned tx_idle_pct = 36;
  int unsigned rx_idle_pct = 67;

  memory_bus_decoder_with_interrupts_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_address      (in_address),
    .in_write_data   (in_write_data),
    .in_irq_raise    (in_irq_raise),
    .in_cpu_busy     (in_cpu_busy),
    .in_cpu_accepts  (in_cpu_accepts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_target      (out_target),
    .out_offset      (out_offset),
    .out_read_data   (out_read_data),
    .out_serial_valid(out_serial_valid),
    .out_serial_byte (out_serial_byte),
    .out_irq_request (out_irq_request),
    .out_irq_index   (out_irq_index)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic bus_result_t apply_bus_word(input bus_word_t w);
    bus_result_t r;
    logic [15:0] a;
    logic [4:0]  pend;
    int          hi;
    r = '0;
    r.target = TGT_IGNORED;
    a = w.addr;
    case (w.op)
      OP_READ: begin
        r.read_data = 8'hFF;
        if (a <= 16'h7FFF) begin
          r.target = (!boot_q[0] && a < 16'h0100) ? TGT_BOOT : TGT_CART;
          r.offset = a[14:0];
          r.read_data = 8'h00;
        end else if (a <= 16'h9FFF) begin
          r.target = TGT_VRAM;
          r.offset = 15'(a - 16'h8000);
          r.read_data = 8'h00;
        end else if (a <= 16'hBFFF) begin
          r.target = TGT_XRAM;
          r.offset = 15'(a - 16'hA000);
          r.read_data = 8'h00;
        end else if (a <= 16'hDFFF) begin
          r.target = TGT_LOCAL;
          r.offset = 15'(a - 16'hC000);
          r.read_data = wram_model[a - 16'hC000];
        end else if (a >= 16'hFE00 && a <= 16'hFE9F) begin
          r.target = TGT_OAM;
          r.offset = 15'(a - 16'hFE00);
          r.read_data = 8'h00;
        end else if (a == ADDR_JOYP) begin
          r.target = TGT_LOCAL;
          r.read_data = joyp_q;
        end else if (a == ADDR_SB) begin
          r.target = TGT_LOCAL;
          r.read_data = sb_q;
        end else if (a == ADDR_SC) begin
          r.target = TGT_LOCAL;
          r.offset = 15'd1;
          r.read_data = sc_q;
        end else if (a >= 16'hFF04 && a <= 16'hFF07) begin
          r.target = TGT_TIMER;
          r.offset = 15'(a - 16'hFF04);
          r.read_data = 8'h00;
        end else if (a >= 16'hFF10 && a <= 16'hFF26) begin
          r.target = TGT_SOUND;
          r.offset = 15'(a - 16'hFF10);
          r.read_data = 8'h00;
        end else if (a >= 16'hFF40 && a <= 16'hFF4B) begin
          r.target = TGT_DISPLAY;
          r.offset = 15'(a - 16'hFF40);
          r.read_data = 8'h00;
        end else if (a == ADDR_IF) begin
          r.target = TGT_LOCAL;
          r.read_data = if_q;
        end else if (a == ADDR_BOOT) begin
          r.target = TGT_LOCAL;
          r.read_data = boot_q;
        end else if (a >= 16'hFF80 && a <= 16'hFFFE) begin
          r.target = TGT_LOCAL;
          r.offset = 15'(a - 16'hFF80);
          r.read_data = hram_model[a - 16'hFF80];
        end else if (a == ADDR_IE) begin
          r.target = TGT_LOCAL;
          r.read_data = ie_q;
        end
      end
      OP_WRITE: begin
        if (a <= 16'h7FFF) begin
          r.target = TGT_CART;
          r.offset = a[14:0];
        end else if (a <= 16'h9FFF) begin
          r.target = TGT_VRAM;
          r.offset = 15'(a - 16'h8000);
        end else if (a <= 16'hBFFF) begin
          r.target = TGT_XRAM;
          r.offset = 15'(a - 16'hA000);
        end else if (a <= 16'hDFFF) begin
          r.target = TGT_LOCAL;
          r.offset = 15'(a - 16'hC000);
          wram_model[a - 16'hC000] = w.data;
        end else if (a >= 16'hFE00 && a <= 16'hFE9F) begin
          r.target = TGT_OAM;
          r.offset = 15'(a - 16'hFE00);
        end else if (a < 16'hFE00) begin
          r.target = TGT_ERROR;
          r.offset = 15'(a - 16'hE000);
        end else if (a == ADDR_JOYP) begin
          r.target = TGT_LOCAL;
          joyp_q = (joyp_q & 8'hCF) | (w.data & 8'h30);
        end else if (a == ADDR_SB || a == ADDR_SC) begin
          r.target = TGT_LOCAL;
          r.offset = 15'(a - ADDR_SB);
          if (a == ADDR_SB) begin
            sb_q = w.data;
          end else begin
            sc_q = (sc_q & 8'h7E) | (w.data & 8'h81);
          end
          if (sc_q == 8'hFF) begin
            r.serial_valid = 1'b1;
            r.serial_byte = sb_q;
            sc_q = sc_q & 8'h7F;
          end
        end else if (a >= 16'hFF04 && a <= 16'hFF07) begin
          r.target = TGT_TIMER;
          r.offset = 15'(a - 16'hFF04);
        end else if (a >= 16'hFF10 && a <= 16'hFF26) begin
          r.target = TGT_SOUND;
          r.offset = 15'(a - 16'hFF10);
        end else if (a >= 16'hFF40 && a <= 16'hFF4B) begin
          r.target = TGT_DISPLAY;
          r.offset = 15'(a - 16'hFF40);
        end else if (a == ADDR_IF) begin
          r.target = TGT_LOCAL;
          if_q = (if_q & 8'hE0) | (w.data & 8'h1F);
        end else if (a == ADDR_BOOT) begin
          if (!boot_q[0]) begin
            r.target = TGT_LOCAL;
            boot_q[0] = w.data[0];
          end
        end else if (a >= 16'hFF80 && a <= 16'hFFFE) begin
          hi = a - 16'hFF80;
          r.target = TGT_LOCAL;
          r.offset = 15'(hi);
          hram_model[hi] = w.data;
          if (!hram_seen[hi]) begin
            hram_seen[hi] = 1'b1;
            hram_used.push_back(hi);
          end
        end else if (a == ADDR_IE) begin
          r.target = TGT_LOCAL;
          ie_q = w.data;
        end
      end
      OP_TICK: begin
        if_q[4:0] = if_q[4:0] | w.raise;
        if (!w.busy) begin
          pend = if_q[4:0] & ie_q[4:0];
          for (int i = 0; i < 5; i++) begin
            if (pend[i] && !r.irq_request) begin
              r.irq_request = 1'b1;
              r.irq_index = 3'(i);
            end
          end
          if (r.irq_request && w.accepts) begin
            if_q[r.irq_index] = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic send_word(input bus_word_t w, input bit typed, input bus_result_t typed_r);
    bus_result_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= w.op;
    in_address     <= w.addr;
    in_write_data  <= w.data;
    in_irq_raise   <= w.raise;
    in_cpu_busy    <= w.busy;
    in_cpu_accepts <= w.accepts;
    do @(posedge clk); while (!in_ready);
    pred = apply_bus_word(w);
    awaited_results.push_back(typed ? typed_r : pred);
    words_sent++;
    case (w.op)
      OP_READ:  n_reads++;
      OP_WRITE: n_writes++;
      OP_TICK:  n_ticks++;
      default: begin
      end
    endcase
    if (pred.serial_valid) n_serial++;
    if (pred.irq_request) n_irq++;
  endtask

  task automatic send_full(input logic [1:0] op, input logic [15:0] a, input logic [7:0] d,
                           input logic [4:0] raise, input logic busy, input logic acc);
    bus_word_t w;
    w.op = op;
    w.addr = a;
    w.data = d;
    w.raise = raise;
    w.busy = busy;
    w.accepts = acc;
    send_word(w, 1'b0, '0);
  endtask

  task automatic send_rw(input logic [1:0] op, input logic [15:0] a, input logic [7:0] d);
    send_full(op, a, d, 5'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic send_tick();
    send_full(OP_TICK, 16'($urandom), 8'($urandom),
              ($urandom_range(1) == 0) ? 5'd0 : 5'($urandom),
              $urandom_range(3) == 0, 1'($urandom));
  endtask

  function automatic logic [15:0] wram_addr();
    if ($urandom_range(1) == 0) return 16'hC000 + 16'($urandom_range(15));
    return 16'hC000 + 16'($urandom_range(WORK_RAM_BYTES_DEF - 1));
  endfunction

  function automatic logic [15:0] hram_known_addr();
    return 16'hFF80 + 16'(hram_used[$urandom_range(hram_used.size() - 1)]);
  endfunction

  // steer reads away from high RAM entries that were never written
  function automatic logic [15:0] safe_addr(input logic [1:0] op, input logic [15:0] a);
    if (op == OP_READ && a >= 16'hFF80 && a <= 16'hFFFE && !hram_seen[a - 16'hFF80])
      return hram_known_addr();
    return a;
  endfunction

  task automatic send_random_burst();
    int unsigned pick;
    logic [1:0]  op;
    logic [7:0]  d;
    pick = $urandom_range(99);
    op = ($urandom_range(1) == 0) ? OP_READ : OP_WRITE;
    if (pick < 14) begin
      send_rw(OP_WRITE, wram_addr(), 8'($urandom));
    end else if (pick < 28) begin
      send_rw(OP_READ, wram_addr(), 8'($urandom));
    end else if (pick < 35) begin
      send_rw(OP_WRITE, 16'hFF80 + 16'($urandom_range(HRAM_DEPTH - 1)), 8'($urandom));
    end else if (pick < 42) begin
      send_rw(OP_READ, hram_known_addr(), 8'($urandom));
    end else if (pick < 50) begin
      d = 8'($urandom);
      if ($urandom_range(9) < 7) d = d | 8'h81;
      send_rw(OP_WRITE, ADDR_SB, 8'($urandom));
      send_rw(OP_WRITE, ADDR_SC, d);
      if ($urandom_range(1) == 0) send_rw(OP_READ, ADDR_SC, 8'($urandom));
    end else if (pick < 57) begin
      send_rw(OP_WRITE, ADDR_IE, 8'($urandom));
      send_rw(OP_WRITE, ADDR_IF, 8'($urandom));
      repeat ($urandom_range(1, 4)) send_tick();
      send_rw(OP_READ, ($urandom_range(1) == 0) ? ADDR_IF : ADDR_IE, 8'($urandom));
    end else if (pick < 74) begin
      send_tick();
    end else if (pick < 84) begin
      send_rw(op, safe_addr(op, 16'hFF00 + 16'($urandom_range(255))), 8'($urandom));
    end else if (pick < 90) begin
      send_rw(op, safe_addr(op, 16'($urandom)), 8'($urandom));
    end else if (pick < 94) begin
      case ($urandom_range(4))
        0: send_rw(OP_WRITE, ADDR_JOYP, 8'($urandom));
        1: send_rw(OP_READ, ADDR_JOYP, 8'($urandom));
        2: send_rw(OP_WRITE, ADDR_BOOT, 8'($urandom));
        3: send_rw(OP_READ, ADDR_BOOT, 8'($urandom));
        default: send_rw(OP_READ, 16'($urandom_range(255)), 8'($urandom));
      endcase
    end else if (pick < 97) begin
      send_full(OP_IDLE, 16'($urandom), 8'($urandom), 5'($urandom), 1'($urandom),
                1'($urandom));
    end else begin
      if ($urandom_range(1) == 0)
        send_rw(op, 16'hE000 + 16'($urandom_range(16'h1DFF)), 8'($urandom));
      else
        send_rw(op, 16'hFEA0 + 16'($urandom_range(16'h5F)), 8'($urandom));
    end
  endtask

  function automatic void add_row(input logic [1:0] op, input logic [15:0] a,
                                  input logic [7:0] d, input logic [4:0] raise,
                                  input logic busy, input logic acc, input bit typed,
                                  input logic [3:0] tgt, input logic [14:0] off,
                                  input logic [7:0] rd, input logic sv, input logic [7:0] sb,
                                  input logic irq, input logic [2:0] idx);
    dir_row_t row;
    row.w.op = op;
    row.w.addr = a;
    row.w.data = d;
    row.w.raise = raise;
    row.w.busy = busy;
    row.w.accepts = acc;
    row.typed = typed;
    row.r.target = tgt;
    row.r.offset = off;
    row.r.read_data = rd;
    row.r.serial_valid = sv;
    row.r.serial_byte = sb;
    row.r.irq_request = irq;
    row.r.irq_index = idx;
    dir_rows.push_back(row);
  endfunction

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      bad_fields++;
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin : result_check
    bus_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t ns: result word with nothing expected, actual target 0x%0h", $time,
                 out_target);
        bad_fields++;
      end else begin
        want = awaited_results.pop_front();
        check_field("target", want.target, out_target);
        check_field("offset", want.offset, out_offset);
        check_field("read_data", want.read_data, out_read_data);
        check_field("serial_valid", want.serial_valid, out_serial_valid);
        check_field("serial_byte", want.serial_byte, out_serial_byte);
        check_field("irq_request", want.irq_request, out_irq_request);
        check_field("irq_index", want.irq_index, out_irq_index);
      end
    end
  end

  initial begin
    for (int i = 0; i < WORK_RAM_BYTES_DEF; i++) wram_model[i] = 8'h00;
    for (int i = 0; i < HRAM_DEPTH; i++) begin
      hram_model[i] = 8'h00;
      hram_seen[i] = 1'b0;
    end
    joyp_q = JOYP_RST;
    sb_q   = SB_RST;
    sc_q   = SC_RST;
    if_q   = IF_RST;
    ie_q   = IE_RST;
    boot_q = BOOT_RST;

    add_row(OP_READ,  ADDR_JOYP, 8'h00, 5'h00, 0, 0, 1, TGT_LOCAL, 15'h0000, 8'hCF, 0, 8'h00, 0, 0);
    add_row(OP_READ,  ADDR_SC,   8'h00, 5'h00, 0, 0, 1, TGT_LOCAL, 15'h0001, 8'h7E, 0, 8'h00, 0, 0);
    add_row(OP_READ,  ADDR_IF,   8'hFF, 5'h1F, 1, 1, 1, TGT_LOCAL, 15'h0000, 8'hE1, 0, 8'h00, 0, 0);
    add_row(OP_READ,  ADDR_IE,   8'h00, 5'h00, 0, 0, 1, TGT_LOCAL, 15'h0000, 8'hE0, 0, 8'h00, 0, 0);
    add_row(OP_READ,  ADDR_BOOT, 8'h00, 5'h00, 0, 0, 1, TGT_LOCAL, 15'h0000, 8'hFF, 0, 8'h00, 0, 0);
    add_row(OP_READ,  16'hC000,  8'h00, 5'h00, 0, 0, 1, TGT_LOCAL, 15'h0000, 8'h00, 0, 8'h00, 0, 0);
    add_row(OP_READ,  16'hDFFF,  8'h00, 5'h00, 0, 0, 1, TGT_LOCAL, 15'h1FFF, 8'h00, 0, 8'h00, 0, 0);
    add_row(OP_READ,  16'h0000,  8'h00, 5'h00, 0, 0, 1, TGT_CART,  15'h0000, 8'h00, 0, 8'h00, 0, 0);
    add_row(OP_READ,  16'h7FFF,  8'h00, 5'h00, 0, 0, 1, TGT_CART,  15'h7FFF, 8'h00, 0, 8'h00, 0, 0);
    add_row(OP_READ,  16'hFF03,  8'h00, 5'h00, 0, 0, 1, TGT_IGNORED, 15'h0, 8'hFF, 0, 8'h00, 0, 0);
    add_row(OP_WRITE, 16'hE000,  8'hAA, 5'h00, 0, 0, 1, TGT_ERROR, 15'h0000, 8'h00, 0, 8'h00, 0, 0);
    add_row(OP_WRITE, 16'hFDFF,  8'h55, 5'h00, 0, 0, 1, TGT_ERROR, 15'h1DFF, 8'h00, 0, 8'h00, 0, 0);
    add_row(OP_WRITE, 16'hFEA0,  8'hFF, 5'h00, 0, 0, 1, TGT_IGNORED, 15'h0, 8'h00, 0, 8'h00, 0, 0);
    add_row(OP_WRITE, ADDR_BOOT, 8'h00, 5'h00, 0, 0, 1, TGT_IGNORED, 15'h0, 8'h00, 0, 8'h00, 0, 0);
    add_row(OP_WRITE, 16'hC000,  8'hFF, 5'h00, 0, 0, 1, TGT_LOCAL, 15'h0000, 8'h00, 0, 8'h00, 0, 0);
    add_row(OP_READ,  16'hC000,  8'h00, 5'h00, 0, 0, 1, TGT_LOCAL, 15'h0000, 8'hFF, 0, 8'h00, 0, 0);
    add_row(OP_WRITE, 16'hFF80,  8'h5A, 5'h00, 0, 0, 1, TGT_LOCAL, 15'h0000, 8'h00, 0, 8'h00, 0, 0);
    add_row(OP_READ,  16'hFF80,  8'h00, 5'h00, 0, 0, 0, '0, '0, '0, 0, '0, 0, 0);
    add_row(OP_WRITE, 16'hFFFE,  8'h00, 5'h00, 0, 0, 1, TGT_LOCAL, 15'h007E, 8'h00, 0, 8'h00, 0, 0);
    add_row(OP_WRITE, ADDR_SB,   8'hA5, 5'h00, 0, 0, 1, TGT_LOCAL, 15'h0000, 8'h00, 0, 8'h00, 0, 0);
    add_row(OP_WRITE, ADDR_SC,   8'h81, 5'h00, 0, 0, 1, TGT_LOCAL, 15'h0001, 8'h00, 1, 8'hA5, 0, 0);
    add_row(OP_READ,  ADDR_SC,   8'h00, 5'h00, 0, 0, 0, '0, '0, '0, 0, '0, 0, 0);
    add_row(OP_WRITE, ADDR_IE,   8'h1F, 5'h00, 0, 0, 1, TGT_LOCAL, 15'h0000, 8'h00, 0, 8'h00, 0, 0);
    add_row(OP_TICK,  16'hFFFF,  8'hFF, 5'h1F, 0, 1, 1, TGT_IGNORED, 15'h0, 8'h00, 0, 8'h00, 1, 0);
    add_row(OP_TICK,  16'h0000,  8'h00, 5'h00, 1, 0, 1, TGT_IGNORED, 15'h0, 8'h00, 0, 8'h00, 0, 0);
    add_row(OP_IDLE,  16'h1234,  8'h00, 5'h00, 0, 0, 1, TGT_IGNORED, 15'h0, 8'h00, 0, 8'h00, 0, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].r);

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 67 : 0;
      rx_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 36 : 0;
      while (words_sent < dir_rows.size() + (phase + 1) * 134) send_random_burst();
      // hold the sender until the block has drained
      in_valid <= 1'b0;
      @(posedge clk);
      while (awaited_results.size() != 0) @(posedge clk);
    end

    repeat (10) @(posedge clk);
    $display("covered %0d words: %0d reads, %0d writes, %0d ticks, the rest idle",
             words_sent, n_reads, n_writes, n_ticks);
    $display("serial bytes emitted: %0d, interrupt requests: %0d", n_serial, n_irq);
    if (bad_fields == 0 && awaited_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire

[memory_bus_decoder_with_interrupts_top.f]
hw/rtl/mbdi_pkg.sv
hw/rtl/mbdi_ram.sv
hw/rtl/mbdi_decode.sv
hw/rtl/memory_bus_decoder_with_interrupts_top.sv
bench/tb_memory_bus_decoder_with_interrupts_top.sv
